### sv/lomsc_pkg.sv
// ---------------------------------------------------------------------------
// lomsc_pkg
// Shared types, widths and helpers of the layered offset min-sum check node.
// ---------------------------------------------------------------------------
package lomsc_pkg;

	// default and widest supported row degree
	localparam int MAX_DEGREE_DEF = 32;
	localparam int DEG_HI         = 64;
	localparam int POS_W          = $clog2(DEG_HI);

	// field widths
	localparam int LLR_W   = 16;
	localparam int EXT_W   = 17;
	localparam int MAG_W   = 17;
	localparam int CFG_W   = 15;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT = 1'b1;

	// running minimum start value, larger than any magnitude
	localparam logic [MAG_W-1:0] MIN_INIT = '1;
	localparam logic [CFG_W-1:0] MSG_MAX  = '1;

	typedef struct packed {
		logic signed [LLR_W-1:0] posterior;
		logic signed [LLR_W-1:0] old_message;
		logic                    row_end;
	} edge_item_t;

	typedef struct packed {
		logic signed [LLR_W-1:0] new_message;
		logic signed [LLR_W-1:0] new_posterior;
		logic                    parity_fail;
		logic                    last_out;
	} result_item_t;

	// summary of one finished row, handed from front to back
	typedef struct packed {
		logic [MAG_W-1:0] first_min;
		logic [MAG_W-1:0] second_min;
		logic [POS_W-1:0] min_pos;
		logic [POS_W-1:0] last_idx;
		logic             parity;
	} row_desc_t;

	// extrinsic store write port
	typedef struct packed {
		logic                    en;
		logic                    bank;
		logic [POS_W-1:0]        idx;
		logic signed [EXT_W-1:0] data;
	} ext_wr_t;

	// row queue status
	typedef struct packed {
		logic full;
		logic empty;
		logic wr_bank;
		logic rd_bank;
	} rowq_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_RUN
	} bk_state_t;

	// offset, floor at zero, optional limit, then message range clamp
	function automatic logic [CFG_W-1:0] shape_mag(
		input logic [MAG_W-1:0] mag,
		input logic [CFG_W-1:0] off,
		input logic [CFG_W-1:0] lim
	);
		logic [MAG_W-1:0] d;
		d = (mag > MAG_W'(off)) ? (mag - MAG_W'(off)) : '0;
		if ((lim != '0) && (d > MAG_W'(lim))) begin
			d = MAG_W'(lim);
		end
		if (d > MAG_W'(MSG_MAX)) begin
			d = MAG_W'(MSG_MAX);
		end
		return d[CFG_W-1:0];
	endfunction

endpackage

### sv/lomsc_front.sv
// ---------------------------------------------------------------------------
// lomsc_front
// Takes edges, forms extrinsics, writes them to the store and tracks the
// two smallest magnitudes, the first minimum position and positive parity.
// ---------------------------------------------------------------------------
module lomsc_front #(
	parameter int MAX_DEGREE = lomsc_pkg::MAX_DEGREE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   edge_valid,
	output logic                   edge_ready,
	input  lomsc_pkg::edge_item_t  edge_item,
	input  lomsc_pkg::rowq_stat_t  q_stat,
	output logic                   push,
	output lomsc_pkg::row_desc_t   push_desc,
	output lomsc_pkg::ext_wr_t     ext_wr
);
	import lomsc_pkg::*;

	localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CW = $clog2(MAX_DEGREE + 1);

	logic [CW-1:0]           count_q;
	logic [MAG_W-1:0]        first_min_q;
	logic [MAG_W-1:0]        second_min_q;
	logic [AW-1:0]           min_pos_q;
	logic                    parity_q;

	logic                    take;
	logic signed [EXT_W-1:0] ext;
	logic                    ext_pos;
	logic [MAG_W-1:0]        mag;
	logic [AW-1:0]           idx;
	logic [CW-1:0]           cnt_nx;
	logic                    close;
	logic [MAG_W-1:0]        first_nx;
	logic [MAG_W-1:0]        second_nx;
	logic [AW-1:0]           pos_nx;
	logic                    parity_nx;

	// a bank is free while the row queue has room
	assign edge_ready = !q_stat.full;
	assign take       = edge_valid && !q_stat.full;

	// extrinsic and its magnitude
	always_comb begin
		ext     = EXT_W'(edge_item.posterior) - EXT_W'(edge_item.old_message);
		ext_pos = !ext[EXT_W-1] && (ext != '0);
		mag     = ext[EXT_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
	end

	// running minima and parity
	always_comb begin
		idx       = count_q[AW-1:0];
		cnt_nx    = count_q + CW'(1);
		close     = edge_item.row_end || (cnt_nx == CW'(MAX_DEGREE));
		parity_nx = parity_q ^ ext_pos;
		first_nx  = first_min_q;
		second_nx = second_min_q;
		pos_nx    = min_pos_q;
		if (mag < first_min_q) begin
			second_nx = first_min_q;
			first_nx  = mag;
			pos_nx    = idx;
		end else if (mag < second_min_q) begin
			second_nx = mag;
		end
	end

	// row summary and store write
	always_comb begin
		push                 = take && close;
		push_desc.first_min  = first_nx;
		push_desc.second_min = second_nx;
		push_desc.min_pos    = POS_W'(pos_nx);
		push_desc.last_idx   = POS_W'(idx);
		push_desc.parity     = parity_nx;
		ext_wr.en            = take;
		ext_wr.bank          = q_stat.wr_bank;
		ext_wr.idx           = POS_W'(idx);
		ext_wr.data          = ext;
	end

	// row state, cleared when a row closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			first_min_q  <= MIN_INIT;
			second_min_q <= MIN_INIT;
			min_pos_q    <= '0;
			parity_q     <= 1'b0;
		end else if (take) begin
			if (close) begin
				count_q      <= '0;
				first_min_q  <= MIN_INIT;
				second_min_q <= MIN_INIT;
				min_pos_q    <= '0;
				parity_q     <= 1'b0;
			end else begin
				count_q      <= cnt_nx;
				first_min_q  <= first_nx;
				second_min_q <= second_nx;
				min_pos_q    <= pos_nx;
				parity_q     <= parity_nx;
			end
		end
	end

endmodule

### sv/lomsc_rowq.sv
// ---------------------------------------------------------------------------
// lomsc_rowq
// Two-entry queue of finished row summaries; its pointers also select the
// store bank that the front fills and the back drains.
// ---------------------------------------------------------------------------
module lomsc_rowq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lomsc_pkg::row_desc_t  push_desc,
	input  logic                  pop,
	output lomsc_pkg::row_desc_t  head_desc,
	output lomsc_pkg::rowq_stat_t stat
);
	import lomsc_pkg::*;

	row_desc_t  desc_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// status and head
	always_comb begin
		stat.full    = (cnt_q == 2'd2);
		stat.empty   = (cnt_q == 2'd0);
		stat.wr_bank = wr_ptr_q;
		stat.rd_bank = rd_ptr_q;
		head_desc    = desc_q[rd_ptr_q];
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			desc_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

### sv/lomsc_back.sv
// ---------------------------------------------------------------------------
// lomsc_back
// Holds the extrinsic store and the configuration, and replays a finished row
// one edge a cycle while not stalled, forming new messages and posteriors.
// ---------------------------------------------------------------------------
module lomsc_back #(
	parameter int MAX_DEGREE = lomsc_pkg::MAX_DEGREE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lomsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lomsc_pkg::CFG_W-1:0]           cfg_data,
	input  lomsc_pkg::ext_wr_t                    ext_wr,
	input  lomsc_pkg::rowq_stat_t                 q_stat,
	input  lomsc_pkg::row_desc_t                  head_desc,
	output logic                                  pop,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output lomsc_pkg::result_item_t               result_item
);
	import lomsc_pkg::*;

	localparam int AW        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int MEM_DEPTH = 2 * MAX_DEGREE;
	localparam int MAW       = $clog2(MEM_DEPTH);

	// configuration
	logic [CFG_W-1:0] offset_q;
	logic [CFG_W-1:0] sat_limit_q;

	// extrinsic store, two banks
	logic signed [EXT_W-1:0] ext_mem [MEM_DEPTH];
	logic [MAW-1:0]          waddr;
	logic [MAW-1:0]          raddr;

	// sequencer
	bk_state_t        state_q;
	bk_state_t        state_nx;
	row_desc_t        desc_q;
	logic [CFG_W-1:0] m1_q;
	logic [CFG_W-1:0] m2_q;
	logic             fail_q;
	logic [AW-1:0]    rd_idx_q;
	logic             issue;
	logic             adv_out;
	logic             load;
	logic             prep;

	// read stage
	logic                    valid_s1;
	logic signed [EXT_W-1:0] ext_s1;
	logic [CFG_W-1:0]        mag_s1;
	logic                    par_s1;
	logic                    fail_s1;
	logic                    last_s1;

	// output register
	logic                    out_valid_q;
	result_item_t            out_q;
	result_item_t            res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			sat_limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET:    offset_q    <= cfg_data;
				REG_SAT_LIMIT: sat_limit_q <= cfg_data;
				default:       offset_q    <= offset_q;
			endcase
		end
	end

	// store addressing
	assign waddr = MAW'(ext_wr.idx[AW-1:0]) + (ext_wr.bank ? MAW'(MAX_DEGREE) : '0);
	assign raddr = MAW'(rd_idx_q) + (q_stat.rd_bank ? MAW'(MAX_DEGREE) : '0);

	always_ff @(posedge clk) begin
		if (ext_wr.en) begin
			ext_mem[waddr] <= ext_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ext_s1 <= ext_mem[raddr];
		end
	end

	// output handshake
	assign adv_out      = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		load     = 1'b0;
		prep     = 1'b0;
		issue    = 1'b0;
		pop      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					load     = 1'b1;
					state_nx = BK_PREP;
				end
			end
			BK_PREP: begin
				prep     = 1'b1;
				state_nx = BK_RUN;
			end
			BK_RUN: begin
				issue = !valid_s1 || adv_out;
				if (issue && (rd_idx_q == desc_q.last_idx[AW-1:0])) begin
					pop      = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// sequencer state and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (prep) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	// row constants
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= head_desc;
		end
		if (prep) begin
			m1_q   <= shape_mag(desc_q.first_min, offset_q, sat_limit_q);
			m2_q   <= shape_mag(desc_q.second_min, offset_q, sat_limit_q);
			fail_q <= desc_q.parity || (desc_q.first_min == '0);
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// per-edge constants follow the read
	always_ff @(posedge clk) begin
		if (issue) begin
			mag_s1  <= (rd_idx_q == desc_q.min_pos[AW-1:0]) ? m2_q : m1_q;
			par_s1  <= desc_q.parity;
			fail_s1 <= fail_q;
			last_s1 <= (rd_idx_q == desc_q.last_idx[AW-1:0]);
		end
	end

	// new message and saturated posterior
	always_comb begin
		logic                    sgn;
		logic signed [LLR_W-1:0] msg;
		logic signed [EXT_W:0]   post;
		sgn  = par_s1 ^ (!ext_s1[EXT_W-1] && (ext_s1 != '0));
		msg  = sgn ? LLR_W'({1'b0, mag_s1}) : -LLR_W'({1'b0, mag_s1});
		post = (EXT_W + 1)'(ext_s1) + (EXT_W + 1)'(msg);
		res.new_message = msg;
		if (post > (EXT_W + 1)'(32767)) begin
			res.new_posterior = 16'sh7fff;
		end else if (post < -(EXT_W + 1)'(32768)) begin
			res.new_posterior = 16'sh8000;
		end else begin
			res.new_posterior = post[LLR_W-1:0];
		end
		res.parity_fail = fail_s1;
		res.last_out    = last_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q <= res;
		end
	end

endmodule

### sv/layered_offset_min_sum_check_node.sv
// ---------------------------------------------------------------------------
// layered_offset_min_sum_check_node
// Check-node update of a layered offset min-sum decoder for one parity row.
//
//   port group    dir   handshake             payload
//   edge_*        in    edge_valid/ready      edge_item_t (one edge)
//   result_*      out   result_valid/ready    result_item_t (one per edge)
//   cfg_*         in    cfg_we, no wait       cfg_index, cfg_data
//
// The front takes one edge item a cycle while a store bank is free.
// A closed row is replayed from its bank one result a cycle while the output
// is not stalled; with the back idle, the first result of a row is offered
// once the row summary is loaded and the offset and limit are applied.
// Two banks let the front fill the next row while the back drains one.
// Reset clears all control state; the store itself is not cleared.
// ---------------------------------------------------------------------------
module layered_offset_min_sum_check_node #(
	parameter int MAX_DEGREE = lomsc_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            edge_valid,
	output logic                            edge_ready,
	input  lomsc_pkg::edge_item_t           edge_item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output lomsc_pkg::result_item_t         result_item,
	input  logic                            cfg_we,
	input  logic [lomsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lomsc_pkg::CFG_W-1:0]     cfg_data
);
	import lomsc_pkg::*;

	logic       push;
	logic       pop;
	row_desc_t  push_desc;
	row_desc_t  head_desc;
	rowq_stat_t q_stat;
	ext_wr_t    ext_wr;

	// edge intake
	lomsc_front #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_valid(edge_valid),
		.edge_ready(edge_ready),
		.edge_item (edge_item),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc),
		.ext_wr    (ext_wr)
	);

	// finished rows waiting for replay
	lomsc_rowq u_rowq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.pop      (pop),
		.head_desc(head_desc),
		.stat     (q_stat)
	);

	// row replay and result output
	lomsc_back #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.ext_wr      (ext_wr),
		.q_stat      (q_stat),
		.head_desc   (head_desc),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item (result_item)
	);

endmodule

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Bench for the layered offset min-sum check node. Edge items are streamed
// in rows of varied length and content, with directed extremes first, then
// random rows under several offset and limit settings and idling patterns.
// A behavioural model of the row update predicts every result item, and
// each accepted result is compared field by field with the oldest one due.
// ---------------------------------------------------------------------------
module tb_top;
	import lomsc_pkg::*;

	localparam int ROW_DEPTH    = 32;
	localparam int MAG_START    = 131071;
	localparam int MSG_CLAMP    = 32767;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 edge_valid   = 1'b0;
	logic                 edge_ready;
	edge_item_t           edge_item    = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_item_t         result_item;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycle_count    = 0;

	// model of the row update: settings, row store and running minima
	int           cfg_offset = 0;
	int           cfg_limit  = 0;
	int           ext_row[ROW_DEPTH];
	int           row_fill   = 0;
	int           low_mag    = MAG_START;
	int           next_mag   = MAG_START;
	int           low_pos    = 0;
	bit           pos_parity = 1'b0;
	result_item_t due_results[$];

	layered_offset_min_sum_check_node u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.edge_valid   (edge_valid),
		.edge_ready   (edge_ready),
		.edge_item    (edge_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[layered_offset_min_sum_check_node] ERROR");
			$finish;
		end
	end

	// result back-pressure
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// offset with floor at zero, optional limit, then message range
	function automatic int trim_magnitude(input int mag);
		int m;
		m = (mag > cfg_offset) ? mag - cfg_offset : 0;
		if (cfg_limit != 0 && m > cfg_limit) begin
			m = cfg_limit;
		end
		if (m > MSG_CLAMP) begin
			m = MSG_CLAMP;
		end
		return m;
	endfunction

	task automatic start_row();
		row_fill   = 0;
		low_mag    = MAG_START;
		next_mag   = MAG_START;
		low_pos    = 0;
		pos_parity = 1'b0;
	endtask

	// take one edge into the row; on row close queue all its result items
	task automatic absorb_edge(input edge_item_t it);
		int           ext;
		int           mag;
		int           slot;
		int           m_low;
		int           m_next;
		int           msg;
		int           post;
		bit           flag;
		bit           positive;
		result_item_t r;
		ext  = int'($signed(it.posterior)) - int'($signed(it.old_message));
		slot = (row_fill >= ROW_DEPTH) ? ROW_DEPTH - 1 : row_fill;
		ext_row[slot] = ext;
		if (ext > 0) begin
			pos_parity = ~pos_parity;
		end
		mag = (ext > 0) ? ext : -ext;
		// a tie goes to the second minimum
		if (mag < low_mag) begin
			next_mag = low_mag;
			low_mag  = mag;
			low_pos  = slot;
		end else if (mag < next_mag) begin
			next_mag = mag;
		end
		row_fill = slot + 1;
		if (!it.row_end && row_fill < ROW_DEPTH) begin
			return;
		end
		flag   = pos_parity || (low_mag <= 0);
		m_low  = trim_magnitude(low_mag);
		m_next = trim_magnitude(next_mag);
		for (int i = 0; i < row_fill; i++) begin
			positive = pos_parity ^ (ext_row[i] > 0);
			msg      = (i == low_pos) ? m_next : m_low;
			if (!positive) begin
				msg = -msg;
			end
			post = ext_row[i] + msg;
			if (post > 32767) begin
				post = 32767;
			end else if (post < -32768) begin
				post = -32768;
			end
			r.new_message   = 16'(msg);
			r.new_posterior = 16'(post);
			r.parity_fail   = flag;
			r.last_out      = (i == row_fill - 1);
			due_results.push_back(r);
		end
		start_row();
	endtask

	// result checking
	always @(posedge clk) begin : result_check
		result_item_t want;
		if (result_valid === 1'b1 && result_ready === 1'b1) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result item %h", result_item));
			end else begin
				want = due_results.pop_front();
				if (result_item.new_message !== want.new_message) begin
					report_mismatch($sformatf("new_message got %0d want %0d",
						$signed(result_item.new_message), $signed(want.new_message)));
				end
				if (result_item.new_posterior !== want.new_posterior) begin
					report_mismatch($sformatf("new_posterior got %0d want %0d",
						$signed(result_item.new_posterior), $signed(want.new_posterior)));
				end
				if (result_item.parity_fail !== want.parity_fail) begin
					report_mismatch($sformatf("parity_fail got %b want %b",
						result_item.parity_fail, want.parity_fail));
				end
				if (result_item.last_out !== want.last_out) begin
					report_mismatch($sformatf("last_out got %b want %b",
						result_item.last_out, want.last_out));
				end
			end
		end
	end

	// one edge item, held until accepted, then an optional idle gap
	task automatic send_edge(input edge_item_t it);
		edge_valid <= 1'b1;
		edge_item  <= it;
		@(posedge clk);
		while (edge_ready !== 1'b1) begin
			@(posedge clk);
		end
		absorb_edge(it);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			edge_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_llrs(input int post, input int old, input bit row_end);
		edge_item_t it;
		it.posterior   = 16'(post);
		it.old_message = 16'(old);
		it.row_end     = row_end;
		send_edge(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		if (idx == REG_OFFSET) begin
			cfg_offset = value & 32'h7fff;
		end else begin
			cfg_limit = value & 32'h7fff;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only once every row has drained
	task automatic set_config(input int offset_val, input int limit_val);
		edge_valid <= 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_OFFSET, offset_val);
		write_reg(REG_SAT_LIMIT, limit_val);
	endtask

	// llr flavours: full range, narrow around zero, or biased to extremes
	function automatic logic [15:0] pick_llr(input int flavour);
		case (flavour)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(80)) - 40);
			default: begin
				case ($urandom_range(4))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	// random rows: mostly short, some single, some full length
	task automatic run_rows(input int n_items, input int idle_pct, input int stall_pct);
		int         sent;
		int         len;
		int         flavour;
		edge_item_t it;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(19))
				14, 15:  len = 1;
				16, 17:  len = $urandom_range(9, ROW_DEPTH - 1);
				18, 19:  len = ROW_DEPTH;
				default: len = $urandom_range(2, 8);
			endcase
			flavour = $urandom_range(2);
			for (int k = 0; k < len; k++) begin
				it.posterior   = pick_llr(flavour);
				it.old_message = pick_llr(flavour);
				// a full row closes by itself whether or not it is marked
				if (k != len - 1) begin
					it.row_end = 1'b0;
				end else if (len == ROW_DEPTH) begin
					it.row_end = 1'($urandom_range(1));
				end else begin
					it.row_end = 1'b1;
				end
				send_edge(it);
			end
			sent += len;
		end
	endtask

	// extremes of the llrs, single-edge rows, zero minimum, ties
	task automatic test_edge_extremes();
		set_config(0, 0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_llrs(32767, -32768, 1'b1);
		send_llrs(-32768, 32767, 1'b1);
		send_llrs(0, 0, 1'b1);
		send_llrs(100, 100, 1'b0);
		send_llrs(5, -3, 1'b1);
		send_llrs(10, 0, 1'b0);
		send_llrs(-10, 0, 1'b0);
		send_llrs(10, 0, 1'b0);
		send_llrs(3, -7, 1'b1);
		send_llrs(32767, 0, 1'b0);
		send_llrs(-32768, 0, 1'b0);
		send_llrs(0, 32767, 1'b0);
		send_llrs(0, -32768, 1'b0);
		send_llrs(-1, 0, 1'b0);
		send_llrs(0, 1, 1'b1);
		send_llrs(50, 20, 1'b0);
		send_llrs(7, 1, 1'b1);
		send_llrs(-20000, 20000, 1'b0);
		send_llrs(20000, -20000, 1'b1);
	endtask

	task automatic test_streaming_no_idle();
		set_config(3, 0);
		run_rows(90, 0, 0);
	endtask

	task automatic test_max_offset_and_limit();
		set_config(32767, 32767);
		run_rows(90, 86, 0);
	endtask

	task automatic test_tight_limit();
		set_config($urandom_range(1, 40), 1);
		run_rows(90, 0, 86);
	endtask

	task automatic test_mixed_settings();
		set_config($urandom_range(0, 2000), $urandom_range(1, 32767));
		run_rows(90, 10, 10);
	endtask

	task automatic test_wide_limit();
		set_config(0, $urandom_range(20000, 32766));
		run_rows(90, 0, 0);
	endtask

	initial begin
		start_row();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_extremes();
		test_streaming_no_idle();
		test_max_offset_and_limit();
		test_tight_limit();
		test_mixed_settings();
		test_wide_limit();
		edge_valid <= 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[layered_offset_min_sum_check_node] OK");
		end else begin
			$display("[layered_offset_min_sum_check_node] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
sv/lomsc_pkg.sv
sv/lomsc_front.sv
sv/lomsc_rowq.sv
sv/lomsc_back.sv
sv/layered_offset_min_sum_check_node.sv
bench/tb_top.sv
